@@ rtl/uas_pkg.sv @@
// shared types and codes for the url authority splitter
package uas_pkg;

    typedef struct packed {
        logic [7:0] char_in;
        logic       is_final;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  char_out;
        logic [2:0]  part;
        logic        done_res;
        logic [2:0]  status;
        logic        tls;
        logic [15:0] resolved_port;
        logic        uri_implied_slash;
    } out_item_t;

    localparam logic [2:0] PART_SCHEME  = 3'd0;
    localparam logic [2:0] PART_SEP     = 3'd1;
    localparam logic [2:0] PART_HOST    = 3'd2;
    localparam logic [2:0] PART_PORT    = 3'd3;
    localparam logic [2:0] PART_URI     = 3'd4;
    localparam logic [2:0] PART_DROPPED = 3'd5;

    localparam logic [2:0] STATUS_OK         = 3'd0;
    localparam logic [2:0] STATUS_BAD_SCHEME = 3'd1;
    localparam logic [2:0] STATUS_BAD_SEP    = 3'd2;
    localparam logic [2:0] STATUS_BAD_HOST   = 3'd3;
    localparam logic [2:0] STATUS_BAD_PORT   = 3'd4;

    localparam logic [7:0] CHAR_SLASH = 8'h2f;
    localparam logic [7:0] CHAR_QUERY = 8'h3f;
    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_COLON = 8'h3a;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_S     = 8'h73;

    localparam logic [15:0] PORT_HTTP  = 16'd80;
    localparam logic [15:0] PORT_HTTPS = 16'd443;
    localparam logic [19:0] PORT_MAX   = 20'd65535;
    localparam logic [2:0]  SCHEME_MAX = 3'd5;
    localparam logic [2:0]  DIGIT_MAX  = 3'd5;

endpackage

@@ rtl/uas_step.sv @@
// parser state and per-byte tagging logic
module uas_step
    import uas_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  in_item_t  item,
    output out_item_t res
);

    typedef enum logic [2:0] {
        ST_SCHEME,
        ST_SLASH1,
        ST_SLASH2,
        ST_HOST,
        ST_PORT,
        ST_URI,
        ST_ERROR
    } stage_t;

    stage_t      stage_reg,         stage_next;
    logic [2:0]  scheme_count_reg,  scheme_count_next;
    logic        prefix_ok_reg,     prefix_ok_next;
    logic        fifth_s_reg,       fifth_s_next;
    logic        host_seen_reg,     host_seen_next;
    logic [2:0]  digit_count_reg,   digit_count_next;
    logic        digits_bad_reg,    digits_bad_next;
    logic [19:0] port_accum_reg,    port_accum_next;
    logic [2:0]  error_code_reg,    error_code_next;
    logic        tls_reg,           tls_next;
    logic [15:0] port_reg,          port_next;

    logic [7:0]  c;
    logic        fin;
    logic        is_digit;
    logic        uri_start;
    logic [19:0] take_accum;
    logic [2:0]  take_count;
    logic        take_bad;
    logic        port_bad_now;
    logic        port_bad_take;
    logic        prefix_match;
    logic        tls_sel;
    logic [2:0]  part;
    logic [2:0]  fail;
    logic [2:0]  status;
    logic        implied;

    assign c         = item.char_in;
    assign fin       = item.is_final;
    assign is_digit  = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    assign uri_start = (c == CHAR_SLASH) || (c == CHAR_QUERY) || (c == CHAR_HASH);

    // multiply by ten as shift and add
    assign take_accum = {port_accum_reg[16:0], 3'b000} + {port_accum_reg[18:0], 1'b0}
                      + {16'd0, c[3:0] - CHAR_ZERO[3:0]};
    assign take_count = digit_count_reg + 3'd1;
    assign take_bad   = digits_bad_reg | ~is_digit;

    assign port_bad_now  = (digit_count_reg == 3'd0) || digits_bad_reg
                         || (port_accum_reg == 20'd0) || (port_accum_reg > PORT_MAX);
    assign port_bad_take = (take_count == 3'd0) || take_bad
                         || (is_digit ? ((take_accum == 20'd0) || (take_accum > PORT_MAX))
                                      : ((port_accum_reg == 20'd0)
                                         || (port_accum_reg > PORT_MAX)));

    always_comb
    begin
        case (scheme_count_reg[1:0])
            2'd0:    prefix_match = (c == 8'h68);
            2'd1:    prefix_match = (c == 8'h74);
            2'd2:    prefix_match = (c == 8'h74);
            2'd3:    prefix_match = (c == 8'h70);
            default: prefix_match = 1'b0;
        endcase
    end

    assign tls_sel = (scheme_count_reg == SCHEME_MAX) && fifth_s_reg;

    always_comb
    begin
        stage_next        = stage_reg;
        scheme_count_next = scheme_count_reg;
        prefix_ok_next    = prefix_ok_reg;
        fifth_s_next      = fifth_s_reg;
        host_seen_next    = host_seen_reg;
        digit_count_next  = digit_count_reg;
        digits_bad_next   = digits_bad_reg;
        port_accum_next   = port_accum_reg;
        error_code_next   = error_code_reg;
        tls_next          = tls_reg;
        port_next         = port_reg;
        part              = PART_DROPPED;
        implied           = 1'b0;
        fail              = STATUS_OK;
        status            = STATUS_OK;

        case (stage_reg)
            ST_SCHEME:
            begin
                if (c == CHAR_SLASH)
                begin
                    if (scheme_count_reg != 3'd0)
                        fail = STATUS_BAD_SCHEME;
                    else
                    begin
                        stage_next = ST_URI;
                        part       = PART_URI;
                    end
                end
                else if (c == CHAR_COLON)
                begin
                    if (scheme_count_reg >= 3'd4 && prefix_ok_reg)
                    begin
                        tls_next   = tls_sel;
                        port_next  = tls_sel ? PORT_HTTPS : PORT_HTTP;
                        stage_next = ST_SLASH1;
                        part       = PART_SEP;
                    end
                    else
                        fail = STATUS_BAD_SCHEME;
                end
                else if (fin || scheme_count_reg >= SCHEME_MAX)
                    fail = STATUS_BAD_SCHEME;
                else
                begin
                    if (scheme_count_reg < 3'd4)
                    begin
                        if (!prefix_match)
                            prefix_ok_next = 1'b0;
                    end
                    else
                        fifth_s_next = (c == CHAR_S);
                    scheme_count_next = scheme_count_reg + 3'd1;
                    part              = PART_SCHEME;
                end
            end
            ST_SLASH1, ST_SLASH2:
            begin
                if (c == CHAR_SLASH)
                begin
                    stage_next = (stage_reg == ST_SLASH1) ? ST_SLASH2 : ST_HOST;
                    part       = PART_SEP;
                end
                else
                    fail = STATUS_BAD_SEP;
            end
            ST_HOST:
            begin
                if (c == CHAR_COLON)
                begin
                    if (!host_seen_reg)
                        fail = STATUS_BAD_HOST;
                    else
                    begin
                        stage_next = ST_PORT;
                        part       = PART_SEP;
                    end
                end
                else if (uri_start)
                begin
                    if (!host_seen_reg)
                        fail = STATUS_BAD_HOST;
                    else
                    begin
                        stage_next = ST_URI;
                        part       = PART_URI;
                    end
                end
                else
                begin
                    host_seen_next = 1'b1;
                    part           = PART_HOST;
                    if (fin)
                    begin
                        implied    = 1'b1;
                        stage_next = ST_URI;
                    end
                end
            end
            ST_PORT:
            begin
                if (uri_start)
                begin
                    if (port_bad_now)
                        fail = STATUS_BAD_PORT;
                    else
                    begin
                        port_next  = port_accum_reg[15:0];
                        stage_next = ST_URI;
                        part       = PART_URI;
                    end
                end
                else if (fin)
                begin
                    if (port_bad_take)
                        fail = STATUS_BAD_PORT;
                    else
                    begin
                        port_next  = take_accum[15:0];
                        implied    = 1'b1;
                        stage_next = ST_URI;
                        part       = PART_PORT;
                    end
                end
                else if (digit_count_reg >= DIGIT_MAX)
                    fail = STATUS_BAD_PORT;
                else
                begin
                    if (is_digit)
                        port_accum_next = take_accum;
                    digits_bad_next  = take_bad;
                    digit_count_next = take_count;
                    part             = PART_PORT;
                end
            end
            ST_URI:
                part = PART_URI;
            default:
                part = PART_DROPPED;
        endcase

        if (fail != STATUS_OK)
        begin
            error_code_next = fail;
            stage_next      = ST_ERROR;
            part            = PART_DROPPED;
        end

        if (fin)
        begin
            status = error_code_next;
            if (status == STATUS_OK)
            begin
                if (stage_next == ST_SLASH1 || stage_next == ST_SLASH2)
                    status = STATUS_BAD_SEP;
                else if (stage_next == ST_HOST)
                    status = STATUS_BAD_HOST;
                else if (stage_next == ST_PORT)
                    status = STATUS_BAD_PORT;
            end
        end

        res.char_out          = c;
        res.part              = part;
        res.done_res          = fin;
        res.status            = status;
        res.tls               = fin && (status == STATUS_OK) && tls_next;
        res.resolved_port     = (fin && (status == STATUS_OK)) ? port_next : 16'd0;
        res.uri_implied_slash = fin && (status == STATUS_OK) && implied;

        // end of url: back to the start
        if (fin)
        begin
            stage_next        = ST_SCHEME;
            scheme_count_next = 3'd0;
            prefix_ok_next    = 1'b1;
            fifth_s_next      = 1'b0;
            host_seen_next    = 1'b0;
            digit_count_next  = 3'd0;
            digits_bad_next   = 1'b0;
            port_accum_next   = 20'd0;
            error_code_next   = STATUS_OK;
            tls_next          = 1'b0;
            port_next         = 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg        <= ST_SCHEME;
            scheme_count_reg <= 3'd0;
            prefix_ok_reg    <= 1'b1;
            fifth_s_reg      <= 1'b0;
            host_seen_reg    <= 1'b0;
            digit_count_reg  <= 3'd0;
            digits_bad_reg   <= 1'b0;
            port_accum_reg   <= 20'd0;
            error_code_reg   <= STATUS_OK;
            tls_reg          <= 1'b0;
            port_reg         <= 16'd0;
        end
        else if (advance)
        begin
            stage_reg        <= stage_next;
            scheme_count_reg <= scheme_count_next;
            prefix_ok_reg    <= prefix_ok_next;
            fifth_s_reg      <= fifth_s_next;
            host_seen_reg    <= host_seen_next;
            digit_count_reg  <= digit_count_next;
            digits_bad_reg   <= digits_bad_next;
            port_accum_reg   <= port_accum_next;
            error_code_reg   <= error_code_next;
            tls_reg          <= tls_next;
            port_reg         <= port_next;
        end
    end

endmodule

@@ rtl/url_authority_splitter_core.sv @@
// top level: input register, parser step, result register
// path: an accepted byte goes from the input register through the parser step into the result register
// throughput: one byte per cycle while result_ready keeps up, set by the single parser step between the registers
// a waiting result holds the input register, so input stalls once both registers are full
// reset: asynchronous active low, clears both valid flags and returns the parser to the scheme
module url_authority_splitter_core
    import uas_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result
);

    logic      hold_valid_reg;
    in_item_t  hold_item_reg;
    logic      result_valid_reg;
    out_item_t result_reg;
    out_item_t step_res;
    logic      advance;

    assign advance    = hold_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !hold_valid_reg || advance;

    uas_step u_step
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (hold_item_reg),
        .res     (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
                hold_valid_reg <= item_valid;
            if (advance)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
            hold_item_reg <= item;
        if (advance)
            result_reg <= step_res;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
